FILE: rtl/core/htrsq_pkg.sv
// Shared types, constants and helpers for the head-insert / tail-remove search queue.
// Used by htrsq_front, htrsq_back and the top level; depends on nothing else.
package htrsq_pkg;

  localparam int DEPTH       = 16;
  localparam int PTR_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int VALUE_W     = 32;
  localparam int ACTION_W    = 2;
  localparam int STATUS_W    = 2;
  localparam int POS_W       = 5;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_DELETE = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_SEARCH = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

  typedef enum logic [1:0] {
    OP_INSERT,
    OP_DELETE,
    OP_SEARCH,
    OP_NOP
  } op_t;

  typedef struct packed {
    op_t                        op;
    logic signed [VALUE_W-1:0]  value;
  } item_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DEL,
    S_SCAN,
    S_RESP
  } state_t;

  function automatic op_t classify(input logic [ACTION_W-1:0] action);
    op_t op;
    unique case (action)
      ACT_INSERT: op = OP_INSERT;
      ACT_DELETE: op = OP_DELETE;
      ACT_SEARCH: op = OP_SEARCH;
      default:    op = OP_NOP;
    endcase
    return op;
  endfunction

  // Slot that lies back steps behind the next-insert slot, modulo DEPTH.
  function automatic logic [PTR_W-1:0] slot_behind(input logic [PTR_W-1:0] newest,
                                                   input logic [CNT_W-1:0] back);
    logic [CNT_W:0] sum;
    sum = (CNT_W + 1)'(newest) + (CNT_W + 1)'(DEPTH) - {1'b0, back};
    if (sum >= (CNT_W + 1)'(DEPTH)) begin
      sum = sum - (CNT_W + 1)'(DEPTH);
    end
    return PTR_W'(sum);
  endfunction

endpackage

FILE: rtl/core/htrsq_front.sv
// Front end: accepts request words, classifies the action and buffers them
// in a two-entry queue. Depends on htrsq_pkg.
module htrsq_front (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  req_valid,
  output logic                                  req_stall,
  input  logic [htrsq_pkg::ACTION_W-1:0]        action,
  input  logic signed [htrsq_pkg::VALUE_W-1:0]  value,
  output logic                                  q_valid,
  output htrsq_pkg::item_t                      q_item,
  input  logic                                  q_pop
);

  htrsq_pkg::item_t                  entries [htrsq_pkg::QUEUE_DEPTH];
  logic [htrsq_pkg::QPTR_W-1:0]      wr_ptr;
  logic [htrsq_pkg::QPTR_W-1:0]      rd_ptr;
  logic [htrsq_pkg::QCNT_W-1:0]      fill;
  logic                              push;
  logic                              pop;

  assign req_stall = (fill == htrsq_pkg::QCNT_W'(htrsq_pkg::QUEUE_DEPTH));
  assign push      = req_valid && !req_stall;
  assign q_valid   = (fill != '0);
  assign pop       = q_pop && q_valid;
  assign q_item    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= '{op: htrsq_pkg::classify(action), value: value};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

FILE: rtl/core/htrsq_back.sv
// Back end: ring-buffer entry store, insert/delete/search sequencer and the
// result register. Depends on htrsq_pkg.
module htrsq_back (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  q_valid,
  input  htrsq_pkg::item_t                      q_item,
  output logic                                  q_pop,
  output logic                                  rsp_valid,
  input  logic                                  rsp_stall,
  output logic [htrsq_pkg::STATUS_W-1:0]        status,
  output logic signed [htrsq_pkg::VALUE_W-1:0]  removed_value,
  output logic [htrsq_pkg::POS_W-1:0]           position
);

  logic signed [htrsq_pkg::VALUE_W-1:0] mem [htrsq_pkg::DEPTH];
  logic signed [htrsq_pkg::VALUE_W-1:0] rd_data;
  logic [htrsq_pkg::PTR_W-1:0]          rd_addr;
  logic                                 mem_we;

  htrsq_pkg::state_t                    state, state_next;
  logic [htrsq_pkg::PTR_W-1:0]          newest, newest_next;
  logic [htrsq_pkg::CNT_W-1:0]          count, count_next;
  logic [htrsq_pkg::CNT_W-1:0]          k, k_next;
  logic signed [htrsq_pkg::VALUE_W-1:0] key;
  logic [htrsq_pkg::STATUS_W-1:0]       res_status, res_status_next;
  logic signed [htrsq_pkg::VALUE_W-1:0] res_removed, res_removed_next;
  logic [htrsq_pkg::POS_W-1:0]          res_pos, res_pos_next;
  logic                                 is_full, is_empty, hit, last, out_free;

  assign is_full  = (count == htrsq_pkg::CNT_W'(htrsq_pkg::DEPTH));
  assign is_empty = (count == '0);
  assign hit      = (rd_data == key);
  assign last     = (k == count);
  assign out_free = !rsp_valid || !rsp_stall;

  // Entry store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[newest] <= q_item.value;
    end
    rd_data <= mem[rd_addr];
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      htrsq_pkg::S_IDLE: begin
        if (q_valid) begin
          unique case (q_item.op)
            htrsq_pkg::OP_DELETE: state_next = is_empty ? htrsq_pkg::S_RESP : htrsq_pkg::S_DEL;
            htrsq_pkg::OP_SEARCH: state_next = is_empty ? htrsq_pkg::S_RESP : htrsq_pkg::S_SCAN;
            default:              state_next = htrsq_pkg::S_RESP;
          endcase
        end
      end
      htrsq_pkg::S_DEL: state_next = htrsq_pkg::S_RESP;
      htrsq_pkg::S_SCAN: begin
        if (hit || last) begin
          state_next = htrsq_pkg::S_RESP;
        end
      end
      htrsq_pkg::S_RESP: begin
        if (out_free) begin
          state_next = htrsq_pkg::S_IDLE;
        end
      end
      default: state_next = htrsq_pkg::S_IDLE;
    endcase
  end

  // Datapath control.
  always_comb begin
    q_pop            = 1'b0;
    mem_we           = 1'b0;
    rd_addr          = '0;
    newest_next      = newest;
    count_next       = count;
    k_next           = k;
    res_status_next  = res_status;
    res_removed_next = res_removed;
    res_pos_next     = res_pos;
    unique case (state)
      htrsq_pkg::S_IDLE: begin
        rd_addr = htrsq_pkg::slot_behind(newest,
                    (q_item.op == htrsq_pkg::OP_DELETE) ? count : htrsq_pkg::CNT_W'(1));
        if (q_valid) begin
          q_pop            = 1'b1;
          k_next           = htrsq_pkg::CNT_W'(1);
          res_status_next  = htrsq_pkg::ST_OK;
          res_removed_next = '0;
          res_pos_next     = '0;
          unique case (q_item.op)
            htrsq_pkg::OP_INSERT: begin
              if (is_full) begin
                res_status_next = htrsq_pkg::ST_FULL;
              end else begin
                mem_we      = 1'b1;
                newest_next = (newest == htrsq_pkg::PTR_W'(htrsq_pkg::DEPTH - 1)) ?
                              '0 : newest + 1'b1;
                count_next  = count + 1'b1;
              end
            end
            htrsq_pkg::OP_DELETE: begin
              if (is_empty) begin
                res_status_next = htrsq_pkg::ST_EMPTY;
              end
            end
            htrsq_pkg::OP_SEARCH: begin
              if (is_empty) begin
                res_status_next = htrsq_pkg::ST_NOT_FOUND;
              end
            end
            default: ;
          endcase
        end
      end
      htrsq_pkg::S_DEL: begin
        res_removed_next = rd_data;
        count_next       = count - 1'b1;
      end
      htrsq_pkg::S_SCAN: begin
        rd_addr = htrsq_pkg::slot_behind(newest, k + 1'b1);
        if (hit) begin
          res_pos_next = htrsq_pkg::POS_W'(k);
        end else if (last) begin
          res_status_next = htrsq_pkg::ST_NOT_FOUND;
        end else begin
          k_next = k + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= htrsq_pkg::S_IDLE;
      newest <= '0;
      count  <= '0;
    end else begin
      state  <= state_next;
      newest <= newest_next;
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    k           <= k_next;
    res_status  <= res_status_next;
    res_removed <= res_removed_next;
    res_pos     <= res_pos_next;
    if (state == htrsq_pkg::S_IDLE && q_valid) begin
      key <= q_item.value;
    end
  end

  // Result register: load when the finished word can leave, drop when taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == htrsq_pkg::S_RESP && out_free) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == htrsq_pkg::S_RESP && out_free) begin
      status        <= res_status;
      removed_value <= res_removed;
      position      <= res_pos;
    end
  end

endmodule

FILE: rtl/core/head_insert_tail_remove_search_queue.sv
// Top level of the head-insert / tail-remove search queue.
// Instantiates htrsq_front and htrsq_back; depends on htrsq_pkg.
//
// Bounded FIFO list of signed 32-bit values kept in a DEPTH-entry ring buffer
// (DEPTH = 16). Each request word carries an action: insert appends a value at
// the newest end (status full and nothing stored when DEPTH entries are held),
// delete removes and returns the oldest value (status empty when none), search
// returns the 1-based position of the first match counted from the newest
// entry (status not found when none); unused action codes return status ok.
// Every request gives exactly one response word. Request words land in a
// two-entry queue, so the requester keeps going until it fills while the
// sequencer works and while a response waits on rsp_stall. The sequencer's
// entry store has one write port and one registered read port. Insert and
// unused codes go from idle straight to the response state, delete passes
// the delete state, a search scans entries newest first until a hit or the
// last (at most DEPTH); empty-list delete and search go straight to response.
module head_insert_tail_remove_search_queue (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  req_valid,
  output logic                                  req_stall,
  input  logic [htrsq_pkg::ACTION_W-1:0]        action,
  input  logic signed [htrsq_pkg::VALUE_W-1:0]  value,
  output logic                                  rsp_valid,
  input  logic                                  rsp_stall,
  output logic [htrsq_pkg::STATUS_W-1:0]        status,
  output logic signed [htrsq_pkg::VALUE_W-1:0]  removed_value,
  output logic [htrsq_pkg::POS_W-1:0]           position
);

  // Classified request word passed from front to back.
  logic             q_valid;
  logic             q_pop;
  htrsq_pkg::item_t q_item;

  htrsq_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .action    (action),
    .value     (value),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  htrsq_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop),
    .rsp_valid     (rsp_valid),
    .rsp_stall     (rsp_stall),
    .status        (status),
    .removed_value (removed_value),
    .position      (position)
  );

endmodule
